/* rtl/mth_pkg.sv */
// Shared types and constants for the mixed tabulation hash pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mth_pkg;

    localparam int TABLE_COUNT = 4;
    localparam int TABLE_DEPTH = 256;
    localparam int SEL_W       = 2;
    localparam int IDX_W       = 8;
    localparam int FIRST_W     = 64;
    localparam int SECOND_W    = 32;
    localparam int KEY_W       = TABLE_COUNT * IDX_W;
    localparam int HASH_W      = 32;
    localparam int OP_W        = 2;

    // Cycles from an accepted hash beat to its done strobe
    localparam int HASH_LATENCY = 5;

    // Operation codes on the op port
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_HASH        = 2'd2
    } op_t;

    // Per-beat control that travels down the pipeline with the data
    typedef struct packed {
        logic wr_first;
        logic wr_second;
        logic hash;
    } mth_ctl_t;

endpackage

/* rtl/mth_first_stage.sv */
// First-table stage: four 256 x 64 tables, written by first-table loads
// and read by the four key bytes of a hash beat. Depends on mth_pkg.
`timescale 1ns / 1ps

module mth_first_stage
    import mth_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mth_ctl_t                            in_ctl,
    input  logic [SEL_W-1:0]                    in_sel,
    input  logic [IDX_W-1:0]                    in_idx,
    input  logic [FIRST_W-1:0]                  in_word,
    input  logic [KEY_W-1:0]                    in_key,
    output mth_ctl_t                            out_ctl,
    output logic [SEL_W-1:0]                    out_sel,
    output logic [IDX_W-1:0]                    out_idx,
    output logic [SECOND_W-1:0]                 out_word,
    output logic [TABLE_COUNT-1:0][FIRST_W-1:0] out_rd
);

    mth_ctl_t              ctl_reg;
    mth_ctl_t              ctl_next;
    logic [SEL_W-1:0]      sel_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [SECOND_W-1:0]   word_reg;

    // First-table writes finish here; only later work moves on
    always_comb
    begin
        ctl_next          = in_ctl;
        ctl_next.wr_first = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Payload for second-table loads
    always_ff @(posedge clk)
    begin
        sel_reg  <= in_sel;
        idx_reg  <= in_idx;
        word_reg <= in_word[SECOND_W-1:0];
    end

    // One memory per table; key byte t addresses table t
    for (genvar t = 0; t < TABLE_COUNT; t++)
    begin : g_tbl
        logic [FIRST_W-1:0] mem [TABLE_DEPTH];
        logic [FIRST_W-1:0] rd_reg;
        logic               we;

        assign we = in_ctl.wr_first && (in_sel == SEL_W'(t));

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[in_idx] <= in_word;
            end
            rd_reg <= mem[in_key[IDX_W*t +: IDX_W]];
        end

        assign out_rd[t] = rd_reg;
    end

    assign out_ctl  = ctl_reg;
    assign out_sel  = sel_reg;
    assign out_idx  = idx_reg;
    assign out_word = word_reg;

endmodule

/* rtl/mth_second_stage.sv */
// Fold, second-table and result stages: XOR of the first-table words,
// four 256 x 32 tables read by the derived bytes, final XOR. Uses mth_pkg.
`timescale 1ns / 1ps

module mth_second_stage
    import mth_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mth_ctl_t                            in_ctl,
    input  logic [SEL_W-1:0]                    in_sel,
    input  logic [IDX_W-1:0]                    in_idx,
    input  logic [SECOND_W-1:0]                 in_word,
    input  logic [TABLE_COUNT-1:0][FIRST_W-1:0] in_rd,
    output logic                                done,
    output logic [HASH_W-1:0]                   hash_value
);

    // Fold stage registers
    mth_ctl_t              f_ctl_reg;
    logic [SEL_W-1:0]      f_sel_reg;
    logic [IDX_W-1:0]      f_idx_reg;
    logic [SECOND_W-1:0]   f_word_reg;
    logic [FIRST_W-1:0]    acc_reg;
    logic [FIRST_W-1:0]    acc_next;

    // Second-table read stage registers
    logic                  r_hash_reg;
    logic [HASH_W-1:0]     low_reg;
    logic [TABLE_COUNT-1:0][SECOND_W-1:0] rd2;

    // Result stage registers
    logic                  done_reg;
    logic [HASH_W-1:0]     hash_reg;
    logic [HASH_W-1:0]     hash_next;

    // XOR of the four first-table words
    always_comb
    begin
        acc_next = '0;
        for (int t = 0; t < TABLE_COUNT; t++)
        begin
            acc_next = acc_next ^ in_rd[t];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_ctl_reg  <= '0;
            r_hash_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            f_ctl_reg  <= in_ctl;
            r_hash_reg <= f_ctl_reg.hash;
            done_reg   <= r_hash_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        f_sel_reg  <= in_sel;
        f_idx_reg  <= in_idx;
        f_word_reg <= in_word;
        acc_reg    <= acc_next;
        low_reg    <= acc_reg[HASH_W-1:0];
    end

    // Second tables; derived byte t (from the upper half) addresses table t
    for (genvar t = 0; t < TABLE_COUNT; t++)
    begin : g_tbl
        logic [SECOND_W-1:0] mem [TABLE_DEPTH];
        logic [SECOND_W-1:0] rd_reg;
        logic                we;

        assign we = f_ctl_reg.wr_second && (f_sel_reg == SEL_W'(t));

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[f_idx_reg] <= f_word_reg;
            end
            rd_reg <= mem[acc_reg[HASH_W + IDX_W*t +: IDX_W]];
        end

        assign rd2[t] = rd_reg;
    end

    // Final XOR into the low half
    always_comb
    begin
        hash_next = low_reg;
        for (int t = 0; t < TABLE_COUNT; t++)
        begin
            hash_next = hash_next ^ rd2[t];
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
    end

    assign done       = done_reg;
    assign hash_value = hash_reg;

endmodule

/* rtl/mixed_tabulation_hash.sv */
// Top level of the mixed tabulation hash: input register, first-table stage,
// second-table stage. Depends on mth_pkg, mth_first_stage, mth_second_stage.
//
//   channel   signals                                         handshake
//   --------  ----------------------------------------------  ---------------------
//   command   op, table_select, entry_index, entry_word, key  start & !busy
//   result    hash_value                                      done, one cycle
//
// One beat enters per cycle; busy stays low. A hash result shows on done after
// its command passes the input register, first-table read, fold, second-table
// read and final XOR stages. Loads write their table in the stage that
// reads it, so every hash sees exactly the loads taken before it.
// Loads and op code 3 give no result. rst_n clears the valid bits only; the
// tables hold garbage until loaded. The receiver cannot stall.
`timescale 1ns / 1ps

module mixed_tabulation_hash
    import mth_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      op,
    input  logic [SEL_W-1:0]     table_select,
    input  logic [IDX_W-1:0]     entry_index,
    input  logic [FIRST_W-1:0]   entry_word,
    input  logic [KEY_W-1:0]     key,
    output logic                 done,
    output logic [HASH_W-1:0]    hash_value
);

    mth_ctl_t                            in_ctl_next;
    mth_ctl_t                            in_ctl_reg;
    logic [SEL_W-1:0]                    sel_reg;
    logic [IDX_W-1:0]                    idx_reg;
    logic [FIRST_W-1:0]                  word_reg;
    logic [KEY_W-1:0]                    key_reg;
    logic                                accept;

    mth_ctl_t                            s2_ctl;
    logic [SEL_W-1:0]                    s2_sel;
    logic [IDX_W-1:0]                    s2_idx;
    logic [SECOND_W-1:0]                 s2_word;
    logic [TABLE_COUNT-1:0][FIRST_W-1:0] s2_rd;

    // Never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode the command beat
    always_comb
    begin
        in_ctl_next = '0;
        if (accept)
        begin
            unique case (op)
                OP_LOAD_FIRST:  in_ctl_next.wr_first  = 1'b1;
                OP_LOAD_SECOND: in_ctl_next.wr_second = 1'b1;
                OP_HASH:        in_ctl_next.hash      = 1'b1;
                default:        in_ctl_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ctl_reg <= '0;
        end
        else
        begin
            in_ctl_reg <= in_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= table_select;
        idx_reg  <= entry_index;
        word_reg <= entry_word;
        key_reg  <= key;
    end

    mth_first_stage u_first
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (in_ctl_reg),
        .in_sel   (sel_reg),
        .in_idx   (idx_reg),
        .in_word  (word_reg),
        .in_key   (key_reg),
        .out_ctl  (s2_ctl),
        .out_sel  (s2_sel),
        .out_idx  (s2_idx),
        .out_word (s2_word),
        .out_rd   (s2_rd)
    );

    mth_second_stage u_second
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ctl     (s2_ctl),
        .in_sel     (s2_sel),
        .in_idx     (s2_idx),
        .in_word    (s2_word),
        .in_rd      (s2_rd),
        .done       (done),
        .hash_value (hash_value)
    );

endmodule

/* rtl/mth_checker.sv */
// Port-level checks for mixed_tabulation_hash, bound to the top level.
// Depends on mth_pkg.
`timescale 1ns / 1ps

module mth_checker
    import mth_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic [OP_W-1:0]      op,
    input logic                 done,
    input logic [HASH_W-1:0]    hash_value
);

    // Pipeline never pushes back
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // Every hash beat gives a done strobe after the pipeline latency
    a_hash_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_HASH) |-> ##HASH_LATENCY done)
        else $error("hash beat lost");

    // Loads and unused codes give no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op != OP_HASH) |-> ##HASH_LATENCY !done)
        else $error("result from a non-hash beat");

    // No result without a matching hash beat
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && op == OP_HASH, HASH_LATENCY))
        else $error("spurious done");

    // A result beat carries defined data once its entries are loaded
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(hash_value))
        else $error("unknown hash_value on done");

endmodule

bind mixed_tabulation_hash mth_checker u_mth_checker (.*);
